FILE: sv/aesr_pkg.sv
`timescale 1ns / 1ps

package aesr_pkg;

  localparam int StampW  = 63;
  localparam int WindowW = 24;
  localparam int SizeW   = 10;
  localparam int PosW    = 9;
  localparam int LevelW  = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 24;

  localparam logic [CfgIdxW-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [WindowW-1:0] WINDOW_RESET = 24'd10000;
  localparam logic [SizeW-1:0]   WIDTH_RESET  = 10'd512;
  localparam logic [SizeW-1:0]   HEIGHT_RESET = 10'd512;

  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [LevelW-1:0] LEVEL_FULL = 8'd255;
  localparam logic [LevelW-1:0] LEVEL_NONE = 8'd0;

  typedef struct packed {
    logic              action;
    logic [PosW-1:0]   pos_x;
    logic [PosW-1:0]   pos_y;
    logic              polarity;
    logic [StampW-1:0] stamp;
  } item_t;

  typedef struct packed {
    logic [LevelW-1:0] green_level;
    logic [LevelW-1:0] red_level;
    logic              in_range;
  } result_t;

  typedef struct packed {
    logic clear;
    logic store;
    logic read;
    logic level;
    logic step;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_last;
  } dp_status_t;

endpackage

FILE: sv/aesr_datapath.sv
`timescale 1ns / 1ps

module aesr_datapath import aesr_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  item_t              item,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  output result_t            result
);

  localparam int Depth  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int DimW   = 13;
  localparam int NumW   = 32;
  localparam int DivW   = WindowW + LevelW - 1;

  logic [StampW-1:0]  on_mem  [Depth];
  logic [StampW-1:0]  off_mem [Depth];

  logic [WindowW-1:0] win_len;
  logic [SizeW-1:0]   image_width;
  logic [SizeW-1:0]   image_height;
  logic [StampW-1:0]  latest;
  logic [AddrW-1:0]   clr_addr;

  logic               in_frame;
  logic [31:0]        addr_wide;
  logic [AddrW-1:0]   addr;

  logic               in_frame_q;
  logic [StampW-1:0]  rd [2];
  logic [StampW:0]    sum [2];
  logic [StampW+1:0]  diff [2];
  logic               lane_zero [2];
  logic               lane_full [2];
  logic [NumW-1:0]    rem [2];
  logic [LevelW-1:0]  quo [2];
  logic [DivW-1:0]    dv;
  logic [2:0]         step_cnt;
  logic [LevelW-1:0]  lvl [2];

  assign in_frame = ({1'b0, item.pos_x} < image_width) &&
                    ({1'b0, item.pos_y} < image_height) &&
                    ({4'b0, item.pos_x} < DimW'(MAX_WIDTH)) &&
                    ({4'b0, item.pos_y} < DimW'(MAX_HEIGHT));

  assign addr_wide = 32'(item.pos_y) * 32'(MAX_WIDTH) + 32'(item.pos_x);
  assign addr      = in_frame ? addr_wide[AddrW-1:0] : '0;

  assign status.clear_last = (clr_addr == AddrW'(Depth - 1));
  assign status.div_last   = (step_cnt == 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len      <= WINDOW_RESET;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW: win_len      <= cfg_data[WindowW-1:0];
        CFG_WIDTH:  image_width  <= cfg_data[SizeW-1:0];
        CFG_HEIGHT: image_height <= cfg_data[SizeW-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latest   <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + AddrW'(1);
      end
      if (cmd.store && in_frame && (item.stamp > latest)) begin
        latest <= item.stamp;
      end
    end
  end

  // ON store
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      on_mem[clr_addr] <= '0;
    end else if (cmd.store && in_frame && item.polarity) begin
      on_mem[addr] <= item.stamp;
    end
    if (cmd.read) begin
      rd[0] <= on_mem[addr];
    end
  end

  // OFF store
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      off_mem[clr_addr] <= '0;
    end else if (cmd.store && in_frame && !item.polarity) begin
      off_mem[addr] <= item.stamp;
    end
    if (cmd.read) begin
      rd[1] <= off_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      in_frame_q <= in_frame;
    end
  end

  // decay arithmetic, one lane per polarity
  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      sum[i]  <= {1'b0, rd[i]} + {40'b0, win_len};
      diff[i] <= {1'b0, sum[i]} - {2'b0, latest};
      if (cmd.level) begin
        lane_zero[i] <= (rd[i] == '0) || diff[i][StampW+1] || (diff[i] == '0);
        lane_full[i] <= (diff[i][StampW:0] >= {40'b0, win_len});
        rem[i]       <= {diff[i][WindowW-1:0], 8'b0} - {8'b0, diff[i][WindowW-1:0]};
        quo[i]       <= '0;
      end else if (cmd.step) begin
        if (rem[i] >= {1'b0, dv}) begin
          rem[i] <= rem[i] - {1'b0, dv};
          quo[i] <= {quo[i][LevelW-2:0], 1'b1};
        end else begin
          quo[i] <= {quo[i][LevelW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.level) begin
      dv       <= {win_len, 7'b0};
      step_cnt <= 3'd7;
    end else if (cmd.step) begin
      dv       <= dv >> 1;
      step_cnt <= step_cnt - 3'd1;
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (!in_frame_q || lane_zero[i]) begin
        lvl[i] = LEVEL_NONE;
      end else if (lane_full[i]) begin
        lvl[i] = LEVEL_FULL;
      end else begin
        lvl[i] = quo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result.green_level <= lvl[0];
      result.red_level   <= lvl[1];
      result.in_range    <= in_frame_q;
    end
  end

endmodule

FILE: sv/aesr_ctrl.sv
`timescale 1ns / 1ps

module aesr_ctrl import aesr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_action,
  output logic       item_stall,
  output logic       result_valid,
  input  logic       result_stall,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SUM,
    S_DIFF,
    S_LEVEL,
    S_DIVIDE,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  assign cmd.clear = (state == S_CLEAR);
  assign cmd.store = accept && (item_action == ACT_STORE);
  assign cmd.read  = accept && (item_action == ACT_QUERY);
  assign cmd.level = (state == S_LEVEL);
  assign cmd.step  = (state == S_DIVIDE);
  assign cmd.load  = (state == S_FINISH) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (status.clear_last) state_next = S_IDLE;
      S_IDLE:   if (cmd.read) state_next = S_SUM;
      S_SUM:    state_next = S_DIFF;
      S_DIFF:   state_next = S_LEVEL;
      S_LEVEL:  state_next = S_DIVIDE;
      S_DIVIDE: if (status.div_last) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (state == S_CLEAR) && !result_valid)
    else $error("reset did not restart the clearing pass");

  a_clear_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) && !status.clear_last |=> (state == S_CLEAR))
    else $error("clearing pass left early");

  a_store_one_cycle: assert property (@(posedge clk) disable iff (rst)
    cmd.store |=> (state == S_IDLE))
    else $error("store beat did not finish in one cycle");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_FINISH))
    else $error("result appeared without a finished query");

  a_level_to_divide: assert property (@(posedge clk) disable iff (rst)
    (state == S_LEVEL) |=> (state == S_DIVIDE) && $past(cmd.level))
    else $error("divide did not follow level setup");

endmodule

FILE: sv/active_event_surface_render_unit.sv
`timescale 1ns / 1ps
// Store beat: accepted while idle; the next beat may follow in the next cycle.
// Query beat: read, sum, diff, level, 8 divide steps, finish, then result valid; no new beat
//   is taken until finish ends, and finish waits while a pending result is stalled.
// Reset: synchronous; clears latest time, config to defaults, then a clearing pass over all
//   MAX_WIDTH*MAX_HEIGHT addresses zeroes both stamp stores with item_stall held high.

module active_event_surface_render_unit import aesr_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  aesr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_action  (item.action),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  aesr_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule
